### hdl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZ77 window encoder package
// Shared constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int WINDOW_DEPTH    = 256;
    localparam int LOOKAHEAD_DEPTH = 16;
    localparam int MATCH_MAX       = 15;
    localparam int WIN_AW          = $clog2(WINDOW_DEPTH);
    localparam int WIN_NW          = $clog2(WINDOW_DEPTH + 1);
    localparam int LA_AW           = $clog2(LOOKAHEAD_DEPTH);
    localparam int LA_CW           = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int WIN_CW          = 9;
    localparam int LA_RW           = 5;

    localparam logic [2:0] REG_WINDOW    = 3'd0;
    localparam logic [2:0] REG_LOOKAHEAD = 3'd4;

    typedef struct packed {
        logic fill;       // fill the whole window with the input symbol
        logic push_la;    // append the input symbol to the lookahead
        logic scan_start; // clear the best match and start at position zero
        logic scan_step;  // compare one window position
        logic shift;      // move one lookahead byte into the window
    } lzw_cmd_t;

    typedef struct packed {
        logic              scan_done;
        logic [3:0]        best_len;
        logic [WIN_AW-1:0] best_pos;
        logic [7:0]        next_sym;
        logic [LA_CW-1:0]  la_count;
    } lzw_stat_t;

endpackage

### hdl/lzw_datapath.sv
// ----------------------------------------------------------------------------
// LZ77 window encoder datapath
// Circular window buffer with a fill mark, lookahead registers, a streaming
// match scan that reads one window byte per cycle and the best-match registers.
// ----------------------------------------------------------------------------
module lzw_datapath
    import lzw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lzw_cmd_t          cmd,
    input  logic [7:0]        in_sym,
    input  logic [WIN_CW-1:0] win_act,
    output lzw_stat_t         stat
);

    logic [7:0]           win_mem [WINDOW_DEPTH];
    logic [7:0]           la_reg  [LOOKAHEAD_DEPTH];
    logic [LA_CW-1:0]     cnt_reg, cnt_next;
    logic [WIN_AW-1:0]    head_reg;
    logic [WIN_NW-1:0]    fcnt_reg;
    logic [7:0]           fsym_reg;
    logic [WIN_CW-1:0]    pos_reg;
    logic [WIN_CW-1:0]    p1_reg;
    logic                 v1_reg;
    logic [7:0]           rd_reg;
    logic                 rd_fill_reg;
    logic [MATCH_MAX-1:0] run_reg, run_next, prev_run;
    logic [3:0]           blen_reg;
    logic [WIN_AW-1:0]    bpos_reg;
    logic [3:0]           cap;
    logic                 issue;
    logic [WIN_NW-1:0]    lidx;
    logic [WIN_AW:0]      psum;
    logic [WIN_AW-1:0]    rd_addr;
    logic                 rd_fill;
    logic [7:0]           wbyte;
    logic [3:0]           hit_len;
    logic [WIN_CW-1:0]    start_p;

    // Window entries older than the fill mark read as the fill symbol.
    always_comb begin
        if (cnt_reg == '0) begin
            cap = 4'd0;
        end else if (cnt_reg > LA_CW'(MATCH_MAX)) begin
            cap = 4'(MATCH_MAX);
        end else begin
            cap = 4'(cnt_reg - LA_CW'(1));
        end
        lidx = WIN_NW'(WINDOW_DEPTH) - WIN_NW'(win_act) + WIN_NW'(pos_reg);
        psum = {1'b0, head_reg} + (WIN_AW + 1)'(lidx);
        if (psum >= (WIN_AW + 1)'(WINDOW_DEPTH)) begin
            rd_addr = WIN_AW'(psum - (WIN_AW + 1)'(WINDOW_DEPTH));
        end else begin
            rd_addr = psum[WIN_AW-1:0];
        end
        rd_fill = ({1'b0, lidx} + {1'b0, fcnt_reg}) < (WIN_NW + 1)'(WINDOW_DEPTH);
    end

    assign issue = cmd.scan_step && (pos_reg < win_act);

    // Bit k of the run vector marks a start k bytes back that still matches.
    always_comb begin
        wbyte    = rd_fill_reg ? fsym_reg : rd_reg;
        prev_run = {run_reg[MATCH_MAX-2:0], 1'b1};
        run_next = '0;
        hit_len  = '0;
        start_p  = p1_reg;
        for (int k = 0; k < MATCH_MAX; k++) begin
            if (prev_run[k] && (k < int'(cap)) && (wbyte == la_reg[k])) begin
                run_next[k] = 1'b1;
                hit_len     = 4'(k + 1);
                start_p     = p1_reg - WIN_CW'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            win_mem[head_reg] <= la_reg[0];
        end
        if (issue) begin
            rd_reg <= win_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) begin
                la_reg[i] <= la_reg[i+1];
            end
        end else if (cmd.push_la && cnt_reg < LA_CW'(LOOKAHEAD_DEPTH)) begin
            la_reg[cnt_reg[LA_AW-1:0]] <= in_sym;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.fill) begin
            cnt_next = '0;
        end else if (cmd.shift) begin
            cnt_next = cnt_reg - LA_CW'(1);
        end else if (cmd.push_la && cnt_reg < LA_CW'(LOOKAHEAD_DEPTH)) begin
            cnt_next = cnt_reg + LA_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            head_reg <= '0;
            fcnt_reg <= '0;
            fsym_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.fill) begin
                fsym_reg <= in_sym;
                fcnt_reg <= '0;
            end else if (cmd.shift) begin
                if (head_reg == WIN_AW'(WINDOW_DEPTH - 1)) begin
                    head_reg <= '0;
                end else begin
                    head_reg <= head_reg + WIN_AW'(1);
                end
                if (fcnt_reg < WIN_NW'(WINDOW_DEPTH)) begin
                    fcnt_reg <= fcnt_reg + WIN_NW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            pos_reg  <= '0;
            v1_reg   <= 1'b0;
            run_reg  <= '0;
            blen_reg <= '0;
            bpos_reg <= '0;
        end else begin
            v1_reg <= issue;
            if (issue) begin
                pos_reg     <= pos_reg + WIN_CW'(1);
                p1_reg      <= pos_reg;
                rd_fill_reg <= rd_fill;
            end
            if (v1_reg) begin
                run_reg <= run_next;
                if (hit_len > blen_reg) begin
                    blen_reg <= hit_len;
                    bpos_reg <= start_p[WIN_AW-1:0];
                end
            end
        end
    end

    assign stat.scan_done = (pos_reg >= win_act) && !v1_reg;
    assign stat.best_len  = blen_reg;
    assign stat.best_pos  = bpos_reg;
    assign stat.next_sym  = la_reg[blen_reg];
    assign stat.la_count  = cnt_reg;

endmodule

### hdl/lzw_controller.sv
// ----------------------------------------------------------------------------
// LZ77 window encoder controller
// Sequences header, lookahead fill, match scan, result hand-off and shift.
// ----------------------------------------------------------------------------
module lzw_controller
    import lzw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             in_eom,
    input  logic [LA_RW-1:0] la_act,
    input  lzw_stat_t        stat,
    output lzw_cmd_t         cmd,
    output logic             out_load,
    output logic             out_hdr,
    output logic             out_last,
    input  logic             out_free
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       started_reg, started_next;
    logic       flush_reg, flush_next;
    logic [3:0] sh_reg, sh_next;
    logic       acc, more;

    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;
    assign more     = flush_reg ? (stat.la_count != '0)
                                : (stat.la_count >= LA_CW'(la_act));

    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        flush_next   = flush_reg;
        sh_next      = sh_reg;
        cmd          = '0;
        out_load     = 1'b0;
        out_hdr      = 1'b0;
        out_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (!started_reg) begin
                        cmd.fill     = 1'b1;
                        out_load     = 1'b1;
                        out_hdr      = 1'b1;
                        out_last     = in_eom;
                        started_next = !in_eom;
                    end else begin
                        cmd.push_la = 1'b1;
                        flush_next  = in_eom;
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (more) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    if (flush_reg) begin
                        started_next = 1'b0;
                        flush_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = flush_reg &&
                                 (stat.la_count == LA_CW'(stat.best_len) + LA_CW'(1));
                    sh_next    = stat.best_len;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                sh_next   = sh_reg - 4'd1;
                if (sh_reg == 4'd0) begin
                    state_next = ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            flush_reg   <= 1'b0;
            sh_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            flush_reg   <= flush_next;
            sh_reg      <= sh_next;
        end
    end

endmodule

### hdl/lz77_window_encoder.sv
// ----------------------------------------------------------------------------
// LZ77 window encoder
// Byte-stream LZ77 encoder with a configurable window and lookahead.
// ----------------------------------------------------------------------------
// The s_ channel takes one byte per item with tlast marking the final byte.
// The first byte of a message fills the window and returns a header item.
// Later bytes fill the lookahead; once it holds lookahead_in_use bytes (or on
// tlast, until it is empty) the block emits triples on the m_ channel.
// Each triple streams the window through a serial compare at one byte per cycle.
// Results sit in an output register; a stalled receiver holds the block in
// its emit step and the next input item waits until the register is free.
// Reset clears the controller and the lookahead count and restores the
// registers to window 256 and lookahead 16. Registers must be written through
// the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module lz77_window_encoder
    import lzw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol[7:0]
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // match_position[7:0], match_length[11:8],
                                   // next_symbol[19:12], zero fill
    output logic        m_tuser,   // is_header
    output logic        m_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WIN_CW-1:0] win_reg;
    logic [LA_RW-1:0]  la_reg;
    logic [WIN_CW-1:0] win_act;
    logic [LA_RW-1:0]  la_act;
    lzw_cmd_t          cmd;
    lzw_stat_t         stat;
    logic              out_load, out_hdr, out_last, out_free;
    logic              valid_reg;
    logic [23:0]       data_reg;
    logic              user_reg, last_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_CW'(256);
            la_reg  <= LA_RW'(16);
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_WINDOW) begin
                win_reg <= pwdata[WIN_CW-1:0];
            end else if (paddr == REG_LOOKAHEAD) begin
                la_reg <= pwdata[LA_RW-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_WINDOW) begin
            prdata = 32'(win_reg);
        end else if (paddr == REG_LOOKAHEAD) begin
            prdata = 32'(la_reg);
        end
    end

    always_comb begin
        win_act = win_reg;
        if (win_act == '0) begin
            win_act = WIN_CW'(1);
        end else if (win_act > WIN_CW'(WINDOW_DEPTH)) begin
            win_act = WIN_CW'(WINDOW_DEPTH);
        end
        la_act = la_reg;
        if (la_act == '0) begin
            la_act = LA_RW'(1);
        end else if (la_act > LA_RW'(LOOKAHEAD_DEPTH)) begin
            la_act = LA_RW'(LOOKAHEAD_DEPTH);
        end
    end

    assign out_free = !valid_reg || m_tready;

    lzw_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_eom   (s_tlast),
        .la_act   (la_act),
        .stat     (stat),
        .cmd      (cmd),
        .out_load (out_load),
        .out_hdr  (out_hdr),
        .out_last (out_last),
        .out_free (out_free)
    );

    lzw_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_sym  (s_tdata),
        .win_act (win_act),
        .stat    (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (out_load) begin
            user_reg <= out_hdr;
            last_reg <= out_last;
            if (out_hdr) begin
                data_reg <= {4'd0, s_tdata, 4'd0, 8'd0};
            end else begin
                data_reg <= {4'd0, stat.next_sym, stat.best_len, stat.best_pos};
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
